>>> sv/b2bcd_pkg.sv
// ----------------------------------------------------------------------------
// b2bcd_pkg
// Shared widths, stage types and the shift-and-add-3 round function.
// ----------------------------------------------------------------------------
package b2bcd_pkg;

	localparam int MAG_BITS    = 96;
	localparam int DIGIT_COUNT = 29;
	localparam int DIG_W       = DIGIT_COUNT * 4;

	// Port field widths (fixed by the interface)
	localparam int LOW_W   = 64;
	localparam int HIGH_W  = 32;
	localparam int DLOW_W  = 64;
	localparam int DHIGH_W = 52;
	localparam int SCALE_W = 5;

	// Data carried from cell to cell
	typedef struct packed {
		logic [DIG_W-1:0]    digits;
		logic [MAG_BITS-1:0] mag;
		logic                negative;
		logic [SCALE_W-1:0]  scale;
	} stage_t;

	// Finished request waiting at the output
	typedef struct packed {
		logic [DIG_W-1:0]   digits;
		logic               negative;
		logic [SCALE_W-1:0] scale;
	} res_t;

	// One double dabble round: add 3 to each digit of 5 or more, then shift
	// the whole digit register left and bring in the next magnitude bit.
	function automatic logic [DIG_W-1:0] dabble_round(
		input logic [DIG_W-1:0] digits,
		input logic             in_bit
	);
		logic [DIG_W-1:0] adj;
		for (int k = 0; k < DIGIT_COUNT; k++) begin
			if (digits[4*k +: 4] >= 4'd5)
				adj[4*k +: 4] = digits[4*k +: 4] + 4'd3;
			else
				adj[4*k +: 4] = digits[4*k +: 4];
		end
		return {adj[DIG_W-2:0], in_bit};
	endfunction

endpackage

>>> sv/b2bcd_cell.sv
// ----------------------------------------------------------------------------
// b2bcd_cell
// One conversion round: registers the digit set after one add-3 and shift.
// ----------------------------------------------------------------------------
module b2bcd_cell import b2bcd_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   en,
	input  logic   valid_in,
	input  stage_t data_in,
	output logic   valid_out,
	output stage_t data_out
);

	logic   valid_q;
	stage_t data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_q.digits   <= dabble_round(data_in.digits, data_in.mag[MAG_BITS-1]);
			data_q.mag      <= {data_in.mag[MAG_BITS-2:0], 1'b0};
			data_q.negative <= data_in.negative;
			data_q.scale    <= data_in.scale;
		end
	end

	assign valid_out = valid_q;
	assign data_out  = data_q;

endmodule

>>> sv/b2bcd_skid.sv
// ----------------------------------------------------------------------------
// b2bcd_skid
// Output register plus one skid entry; the full flag holds the cell chain.
// ----------------------------------------------------------------------------
module b2bcd_skid import b2bcd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  res_t push_data,
	output logic full,
	output logic out_valid,
	output res_t out_data,
	input  logic out_stall
);

	logic out_valid_q;
	logic skid_valid_q;
	res_t out_q;
	res_t skid_q;
	logic take;

	assign take = out_valid_q && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || take) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= push;
			end
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || take) begin
			if (skid_valid_q)
				out_q <= skid_q;
			else if (push)
				out_q <= push_data;
		end else if (push) begin
			skid_q <= push_data;
		end
	end

	assign full      = skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

>>> sv/binary_to_bcd_converter_top.sv
// ----------------------------------------------------------------------------
// binary_to_bcd_converter_top
// 96-bit binary magnitude to 29 packed BCD digits, sign and scale pass along.
// ----------------------------------------------------------------------------
// Input request: valid/stall with magnitude_low, magnitude_high, negative and
// decimal_scale. Result: result_valid/result_stall with digits_low,
// digits_high, negative_out and scale_out. A request moves at an edge where
// valid is high and stall is low.
// Each request runs through a row of 96 identical cells, one double dabble
// round per cell, then an output register. A new request is taken every
// cycle while stall is low.
// When result_stall holds a pending result, one further result drops into a
// skid entry; once that entry is occupied the whole cell row freezes and
// stall goes high until the receiver takes a result.
// Reset clears all valid flags; the row is empty and stall is low after it.
// ----------------------------------------------------------------------------
module binary_to_bcd_converter_top import b2bcd_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                valid,
	output logic                stall,
	input  logic [LOW_W-1:0]    magnitude_low,
	input  logic [HIGH_W-1:0]   magnitude_high,
	input  logic                negative,
	input  logic [SCALE_W-1:0]  decimal_scale,
	output logic                result_valid,
	input  logic                result_stall,
	output logic [DLOW_W-1:0]   digits_low,
	output logic [DHIGH_W-1:0]  digits_high,
	output logic                negative_out,
	output logic [SCALE_W-1:0]  scale_out
);

	localparam int ALL_W = DLOW_W + DHIGH_W;

	logic                advance;
	logic                full;
	logic [MAG_BITS:0]   vld;
	stage_t              stg [MAG_BITS+1];
	res_t                push_data;
	res_t                out_data;
	logic [ALL_W-1:0]    all_digits;

	assign advance = !full;
	assign stall   = full;

	assign vld[0] = valid;
	assign stg[0] = {DIG_W'(0), MAG_BITS'({magnitude_high, magnitude_low}), negative,
		decimal_scale};

	for (genvar i = 0; i < MAG_BITS; i++) begin : g_cell
		b2bcd_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (advance),
			.valid_in  (vld[i]),
			.data_in   (stg[i]),
			.valid_out (vld[i+1]),
			.data_out  (stg[i+1])
		);
	end

	assign push_data.digits   = stg[MAG_BITS].digits;
	assign push_data.negative = stg[MAG_BITS].negative;
	assign push_data.scale    = stg[MAG_BITS].scale;

	b2bcd_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (vld[MAG_BITS] && advance),
		.push_data (push_data),
		.full      (full),
		.out_valid (result_valid),
		.out_data  (out_data),
		.out_stall (result_stall)
	);

	assign all_digits   = ALL_W'(out_data.digits);
	assign digits_low   = all_digits[DLOW_W-1:0];
	assign digits_high  = all_digits[ALL_W-1:DLOW_W];
	assign negative_out = out_data.negative;
	assign scale_out    = out_data.scale;

endmodule
